### hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WORD_W  = 64;
  localparam int KEY_LEN_W   = 5;
  localparam int CFG_INDEX_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 5'd16;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,  // latch transaction, start read of S[i+1] when keyed
    OP_FILL,    // identity fill, one entry a cycle
    OP_KA,      // schedule: read S[n]
    OP_KB,      // schedule: j += S[n] + key, read S[j]
    OP_KC,      // schedule: S[j] <= S[n]
    OP_KD,      // schedule: S[n] <= old S[j], read S[n+1]
    OP_SI,      // stream: i += 1, read S[i]
    OP_SJ,      // stream: j += S[i], read S[j]
    OP_ST,      // stream: S[j] <= S[i], read S[S[i]+S[j]]
    OP_SO       // stream: S[i] <= old S[j], load result
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic keyed;     // key schedule done for this message
    logic n_last;    // sweep counter at its final entry
    logic out_free;  // result register can take a value now
  } dp_status_t;

endpackage

### hw/rtl/rc4_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rc4_datapath.sv
// RC4 datapath: key registers, permutation table, indexes and result register.
`timescale 1ns / 1ps

module rc4_datapath #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rc4_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rc4_pkg::KEY_WORD_W-1:0]     cfg_data,
  input  rc4_pkg::byte_t                     data_byte,
  input  logic                               last_byte,
  input  logic                               out_ready,
  output logic                               out_valid,
  output rc4_pkg::byte_t                     out_byte,
  output logic                               out_last,
  input  rc4_pkg::dp_cmd_t                   cmd,
  output rc4_pkg::dp_status_t                status
);

  localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

  rc4_pkg::byte_t                key_mem [MAX_KEY_BYTES];
  logic [rc4_pkg::KEY_LEN_W-1:0] key_length;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_eff;
  logic [KEY_IDX_W-1:0]          kidx;
  logic                          kidx_wrap;

  rc4_pkg::byte_t n;
  rc4_pkg::byte_t i;
  rc4_pkg::byte_t j;
  rc4_pkg::byte_t si;
  rc4_pkg::byte_t sj;
  rc4_pkg::byte_t t;
  rc4_pkg::byte_t data;
  logic           last;
  logic           keyed;

  rc4_pkg::byte_t ram_waddr;
  rc4_pkg::byte_t ram_wdata;
  rc4_pkg::byte_t ram_raddr;
  rc4_pkg::byte_t ram_rdata;
  logic           ram_we;

  rc4_pkg::byte_t sched_j;
  rc4_pkg::byte_t stream_j;
  rc4_pkg::byte_t ks;

  // Key bytes: byte b sits in lane b mod 8 of its word
  for (genvar b = 0; b < MAX_KEY_BYTES; b++) begin : g_key
    localparam int LANE = b % 8;
    localparam logic [rc4_pkg::CFG_INDEX_W-1:0] SEL =
      (b < 8) ? rc4_pkg::REG_KEY_LOW : rc4_pkg::REG_KEY_HIGH;
    always_ff @(posedge clk) begin
      if (rst) begin
        key_mem[b] <= '0;
      end else if (cfg_we && cfg_index == SEL) begin
        key_mem[b] <= cfg_data[rc4_pkg::BYTE_W*LANE +: rc4_pkg::BYTE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= rc4_pkg::KEY_LENGTH_RESET;
    end else if (cfg_we && cfg_index == rc4_pkg::REG_KEY_LENGTH) begin
      key_length <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
    end
  end

  // Zero length counts as one, anything above the key store saturates
  always_comb begin
    priority if (key_length == '0) begin
      key_len_eff = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      key_len_eff = MAX_LEN;
    end else begin
      key_len_eff = key_length;
    end
  end

  assign kidx_wrap = (rc4_pkg::KEY_LEN_W'(kidx) + rc4_pkg::KEY_LEN_W'(1)) == key_len_eff;

  assign sched_j  = j + ram_rdata + key_mem[kidx];
  assign stream_j = j + ram_rdata;

  // The read of S[t] races both swap writes; patch in the swapped values
  always_comb begin
    priority if (t == j) begin
      ks = si;
    end else if (t == i) begin
      ks = sj;
    end else begin
      ks = ram_rdata;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = n;
    ram_wdata = n;
    ram_raddr = n;
    unique case (cmd.op)
      rc4_pkg::OP_ACCEPT: ram_raddr = i + 8'd1;
      rc4_pkg::OP_FILL:   ram_we = 1'b1;
      rc4_pkg::OP_KA:     ram_raddr = n;
      rc4_pkg::OP_KB:     ram_raddr = sched_j;
      rc4_pkg::OP_KC: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = si;
      end
      rc4_pkg::OP_KD: begin
        ram_we    = 1'b1;
        ram_waddr = n;
        ram_wdata = sj;
        ram_raddr = n + 8'd1;
      end
      rc4_pkg::OP_SI:     ram_raddr = i + 8'd1;
      rc4_pkg::OP_SJ:     ram_raddr = stream_j;
      rc4_pkg::OP_ST: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = si;
        ram_raddr = si + ram_rdata;
      end
      rc4_pkg::OP_SO: begin
        ram_we    = 1'b1;
        ram_waddr = i;
        ram_wdata = sj;
      end
      default: ram_we = 1'b0;
    endcase
  end

  rc4_ram #(
    .WIDTH(rc4_pkg::BYTE_W),
    .DEPTH(rc4_pkg::TABLE_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      i         <= '0;
      j         <= '0;
      kidx      <= '0;
      keyed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == rc4_pkg::OP_SO) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        rc4_pkg::OP_ACCEPT: begin
          if (keyed) begin
            i <= i + 8'd1;
          end else begin
            n    <= '0;
            i    <= '0;
            j    <= '0;
            kidx <= '0;
          end
        end
        rc4_pkg::OP_FILL: n <= n + 8'd1;
        rc4_pkg::OP_KB:   j <= sched_j;
        rc4_pkg::OP_KD: begin
          n    <= n + 8'd1;
          kidx <= kidx_wrap ? '0 : kidx + KEY_IDX_W'(1);
          if (n == 8'hFF) begin
            keyed <= 1'b1;
            j     <= '0;
          end
        end
        rc4_pkg::OP_SI:   i <= i + 8'd1;
        rc4_pkg::OP_SJ:   j <= stream_j;
        rc4_pkg::OP_SO: begin
          if (last) begin
            keyed <= 1'b0;
          end
        end
        default: keyed <= keyed;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rc4_pkg::OP_ACCEPT: begin
        data <= data_byte;
        last <= last_byte;
      end
      rc4_pkg::OP_KB, rc4_pkg::OP_SJ: si <= ram_rdata;
      rc4_pkg::OP_KC: sj <= ram_rdata;
      rc4_pkg::OP_ST: begin
        sj <= ram_rdata;
        t  <= si + ram_rdata;
      end
      rc4_pkg::OP_SO: begin
        out_byte <= data ^ ks;
        out_last <= last;
      end
      default: data <= data;
    endcase
  end

  assign status.keyed    = keyed;
  assign status.n_last   = (n == 8'hFF);
  assign status.out_free = !out_valid || out_ready;

endmodule

### hw/rtl/rc4_ctrl.sv
// RC4 controller: sequences key schedule and keystream steps.
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rc4_pkg::dp_status_t status,
  output rc4_pkg::dp_cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_FILL = 10'b00_0000_0010,
    S_KA   = 10'b00_0000_0100,
    S_KB   = 10'b00_0000_1000,
    S_KC   = 10'b00_0001_0000,
    S_KD   = 10'b00_0010_0000,
    S_SI   = 10'b00_0100_0000,
    S_SJ   = 10'b00_1000_0000,
    S_ST   = 10'b01_0000_0000,
    S_SO   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && status.out_free;

  always_comb begin
    state_next = state;
    cmd.op     = rc4_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = rc4_pkg::OP_ACCEPT;
          state_next = status.keyed ? S_SJ : S_FILL;
        end
      end
      S_FILL: begin
        cmd.op = rc4_pkg::OP_FILL;
        if (status.n_last) begin
          state_next = S_KA;
        end
      end
      S_KA: begin
        cmd.op     = rc4_pkg::OP_KA;
        state_next = S_KB;
      end
      S_KB: begin
        cmd.op     = rc4_pkg::OP_KB;
        state_next = S_KC;
      end
      S_KC: begin
        cmd.op     = rc4_pkg::OP_KC;
        state_next = S_KD;
      end
      S_KD: begin
        cmd.op     = rc4_pkg::OP_KD;
        state_next = status.n_last ? S_SI : S_KB;
      end
      S_SI: begin
        cmd.op     = rc4_pkg::OP_SI;
        state_next = S_SJ;
      end
      S_SJ: begin
        cmd.op     = rc4_pkg::OP_SJ;
        state_next = S_ST;
      end
      S_ST: begin
        cmd.op     = rc4_pkg::OP_ST;
        state_next = S_SO;
      end
      S_SO: begin
        cmd.op     = rc4_pkg::OP_SO;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/rc4_stream_cipher.sv
// Once keyed, a byte runs the accept step, then stream steps SJ, ST and SO, before out_valid;
// the first byte of a message first runs the schedule: fill, KA, a KB/KC/KD swap per entry, SI.
// One byte at a time, taken in idle with the result register free; the single-write-port
// permutation table sets the pace: each byte needs three dependent reads and two swap writes.
// Reset: synchronous, active high; clears indexes, key registers and the keyed flag,
// key_length to 16. Table contents stay undefined until the next key schedule.
`timescale 1ns / 1ps

module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc4_pkg::KEY_WORD_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rc4_pkg::byte_t                  data_byte,
  input  logic                            last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rc4_pkg::byte_t                  out_byte,
  output logic                            out_last
);

  rc4_pkg::dp_cmd_t    cmd;
  rc4_pkg::dp_status_t status;

  rc4_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  rc4_datapath #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_byte (out_byte),
    .out_last (out_last),
    .cmd      (cmd),
    .status   (status)
  );

`ifndef ASSERT_OFF
  // A new transaction is taken only when the result register will be free
  a_accept_out_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input accepted while result pending");

  // A result appears only from the final stream step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == rc4_pkg::OP_SO))
    else $error("result without stream step");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rc4_pkg::OP_SO) |=> out_valid)
    else $error("stream step did not load result");

  // No input is taken while the key schedule runs
  a_busy_schedule: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == rc4_pkg::OP_FILL || cmd.op == rc4_pkg::OP_KD) |-> !in_ready)
    else $error("ready during key schedule");
`endif

endmodule

### dv/rc4_stream_cipher_checker.sv
// Channel monitor, RC4 keystream predictor and result scoreboard for rc4_stream_cipher.
`timescale 1ns / 1ps

module rc4_stream_cipher_checker #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc4_pkg::KEY_WORD_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rc4_pkg::byte_t                  data_byte,
  input  logic                            last_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rc4_pkg::byte_t                  out_byte,
  input  logic                            out_last,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    rc4_pkg::byte_t cipher;
    logic           last;
  } cipher_result_t;

  // Shadow cipher state
  rc4_pkg::byte_t                 sbox [rc4_pkg::TABLE_DEPTH];
  rc4_pkg::byte_t                 ptr_i;
  rc4_pkg::byte_t                 ptr_j;
  logic                           keyed;
  logic [rc4_pkg::KEY_WORD_W-1:0] key_lo;
  logic [rc4_pkg::KEY_WORD_W-1:0] key_hi;
  logic [rc4_pkg::KEY_LEN_W-1:0]  key_len;

  cipher_result_t cipher_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic rc4_pkg::byte_t key_at(input int n);
    if (n < 8) return key_lo[8*n +: 8];
    return key_hi[8*(n-8) +: 8];
  endfunction

  // Identity fill plus 256 swaps, with the key registers as they are now
  function automatic void schedule_key();
    int             len;
    rc4_pkg::byte_t acc;
    rc4_pkg::byte_t t;
    len = (key_len == 0) ? 1 : (key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len);
    for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) sbox[n] = rc4_pkg::byte_t'(n);
    acc = '0;
    for (int n = 0; n < rc4_pkg::TABLE_DEPTH; n++) begin
      acc = rc4_pkg::byte_t'(acc + sbox[n] + key_at(n % len));
      t = sbox[acc];
      sbox[acc] = sbox[n];
      sbox[n] = t;
    end
    ptr_i = '0;
    ptr_j = '0;
    keyed = 1'b1;
  endfunction

  function automatic rc4_pkg::byte_t next_keystream();
    rc4_pkg::byte_t t;
    ptr_i = rc4_pkg::byte_t'(ptr_i + 8'd1);
    ptr_j = rc4_pkg::byte_t'(ptr_j + sbox[ptr_i]);
    t = sbox[ptr_i];
    sbox[ptr_i] = sbox[ptr_j];
    sbox[ptr_j] = t;
    return sbox[rc4_pkg::byte_t'(sbox[ptr_i] + sbox[ptr_j])];
  endfunction

  always @(posedge clk) begin
    cipher_result_t predicted;
    cipher_result_t oldest;
    if (rst) begin
      key_lo  = '0;
      key_hi  = '0;
      key_len = rc4_pkg::KEY_LENGTH_RESET;
      keyed   = 1'b0;
      ptr_i   = '0;
      ptr_j   = '0;
      errors  = 0;
      cipher_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rc4_pkg::REG_KEY_LOW:    key_lo = cfg_data;
          rc4_pkg::REG_KEY_HIGH:   key_hi = cfg_data;
          rc4_pkg::REG_KEY_LENGTH: key_len = cfg_data[rc4_pkg::KEY_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (!keyed) schedule_key();
        predicted.cipher = data_byte ^ next_keystream();
        predicted.last   = last_byte;
        cipher_q.push_back(predicted);
        // last byte closes the message, next one rekeys
        if (last_byte) keyed = 1'b0;
      end
      if (out_valid && out_ready) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("unexpected result, out_byte", int'(out_byte), 0);
        end else begin
          oldest = cipher_q.pop_front();
          if (out_byte !== oldest.cipher) begin
            report_mismatch("out_byte", int'(out_byte), int'(oldest.cipher));
          end
          if (out_last !== oldest.last) begin
            report_mismatch("out_last", int'(out_last), int'(oldest.last));
          end
        end
      end
    end
    pending = cipher_q.size();
  end

endmodule

### dv/rc4_stream_cipher_tb.sv
// Top-level testbench for rc4_stream_cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;

  localparam int ITEM_TARGET = 900;
  localparam int QUIET_AFTER = 780;
  localparam logic [rc4_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] LEN_ZERO = 5'd0;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] LEN_ONE  = 5'd1;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] LEN_FULL = 5'd16;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] LEN_OVER = 5'd17;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] LEN_MAX  = 5'd31;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rc4_pkg::KEY_WORD_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  rc4_pkg::byte_t                  data_byte;
  logic                            last_byte;
  logic                            out_valid;
  logic                            out_ready;
  rc4_pkg::byte_t                  out_byte;
  logic                            out_last;
  int                              errors;
  int                              pending;

  logic stalls_on;
  int   hold;
  int   sent;

  rc4_stream_cipher u_top (.*);

  rc4_stream_cipher_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver back-pressure in random bursts while stalls are on
  always @(posedge clk) begin
    if (hold != 0) begin
      hold      <= hold - 1;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      hold      <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [rc4_pkg::KEY_WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [rc4_pkg::KEY_LEN_W-1:0] pick_key_len();
    case ($urandom_range(0, 5))
      0:       return LEN_ZERO;
      1:       return LEN_ONE;
      2:       return LEN_FULL;
      3:       return ($urandom_range(0, 1) != 0) ? LEN_OVER : LEN_MAX;
      default: return rc4_pkg::KEY_LEN_W'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic write_reg(input logic [rc4_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rc4_pkg::KEY_WORD_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Length write with random junk above the 5-bit field
  task automatic write_key_len(input logic [rc4_pkg::KEY_LEN_W-1:0] len);
    logic [rc4_pkg::KEY_WORD_W-1:0] word;
    word = rand64();
    word[rc4_pkg::KEY_LEN_W-1:0] = len;
    write_reg(rc4_pkg::REG_KEY_LENGTH, word);
  endtask

  task automatic send_byte(input rc4_pkg::byte_t d, input logic l);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    sent++;
    // the tail of the run goes without idling
    if (sent >= QUIET_AFTER) stalls_on <= 1'b0;
  endtask

  task automatic send_message(input int len, input logic close);
    for (int k = 0; k < len; k++) begin
      send_byte(rc4_pkg::byte_t'($urandom), close && (k == len - 1));
    end
  endtask

  // Drop valid, then wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int n_msgs;
    int len;
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = rc4_pkg::REG_KEY_LOW;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    stalls_on = 1'b0;
    sent      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset key: all zero bytes, length 16
    send_byte(8'h00, 1'b1);
    wait_drained();
    write_reg(rc4_pkg::REG_KEY_LOW, '1);
    write_reg(rc4_pkg::REG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    write_key_len(LEN_FULL);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'ha5, 1'b1);
    wait_drained();
    write_key_len(LEN_ZERO);  // acts as length 1
    send_byte(8'h5a, 1'b1);
    wait_drained();
    write_key_len(LEN_MAX);   // saturates to 16
    send_message(2, 1'b1);
    wait_drained();
    write_key_len(LEN_OVER);
    send_message(1, 1'b1);
    wait_drained();
    write_reg(rc4_pkg::REG_KEY_LOW, rand64());
    write_key_len(LEN_ONE);
    send_message(2, 1'b1);
    wait_drained();
    write_reg(REG_UNUSED, rand64());  // must be dropped
    send_message(1, 1'b1);
    wait_drained();
    write_key_len(5'd8);
    send_message(2, 1'b1);
    wait_drained();
    write_key_len(5'd9);
    send_message(2, 1'b1);
    // key change inside a message only hits the next schedule
    send_message(2, 1'b0);
    wait_drained();
    write_reg(rc4_pkg::REG_KEY_LOW, rand64());
    write_reg(rc4_pkg::REG_KEY_HIGH, rand64());
    send_byte(rc4_pkg::byte_t'($urandom), 1'b1);
    send_byte(rc4_pkg::byte_t'($urandom), 1'b1);

    while (sent < ITEM_TARGET) begin
      wait_drained();
      stalls_on <= (sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) != 0) write_reg(rc4_pkg::REG_KEY_LOW, rand64());
      if ($urandom_range(0, 1) != 0) write_reg(rc4_pkg::REG_KEY_HIGH, rand64());
      if ($urandom_range(0, 1) != 0) write_key_len(pick_key_len());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, rand64());
      n_msgs = $urandom_range(1, 4);
      for (int m = 0; m < n_msgs; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
        if (sent + len > ITEM_TARGET) len = (sent < ITEM_TARGET) ? ITEM_TARGET - sent : 1;
        // sometimes leave the phase's last message open across the next key write
        send_message(len, !(m == n_msgs - 1 && $urandom_range(0, 3) == 0));
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
